[src/gsig_pkg.sv]
package gsig_pkg;

	localparam int VTX_W = 11;
	localparam int LEN_W = 7;
	localparam int U_W   = 7;
	localparam int V_W   = 6;
	localparam int STRIP_W = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	typedef logic [VTX_W-1:0] vtx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_U_POINTS  = 3'd0,
		REG_V_POINTS  = 3'd1,
		REG_JOIN_U    = 3'd2,
		REG_JOIN_V    = 3'd3,
		REG_TWIST_U   = 3'd4,
		REG_TWIST_V   = 3'd5,
		REG_CLOCKWISE = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_BASE,
		ST_EMIT,
		ST_CLOSE
	} state_t;

endpackage

[src/grid_strip_index_generator_core.sv]
// Triangle-strip index generator for a row-major grid of u_points rows by
// v_points columns.
//
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while busy is low. Reset loads u_points=2, v_points=2,
// clockwise=1 and clears the other flags; no word is in flight after reset.
//
// Command: strip_number is taken at a clock edge where start is high and busy
// is low. A strip number outside the grid (and not the wrap strip) yields no
// words and busy stays low. Otherwise busy rises and the strip base address
// is built by a shift-add multiply on one shared 11-bit adder, one multiplier
// bit per cycle, ending at the top set bit; the same adder then forms the
// second row base.
//
// Results: one vertex-index pair per cycle, marked by a one-cycle
// result_valid, v_points pairs (v_points held to 2..MAX_V_POINTS) plus one
// closing pair when join_v is set; last_pair flags the final one. The first
// word follows the command through the multiply steps, the base step and the
// result register; no command is taken until the strip is done. The receiver
// has no back-pressure: every word must be taken when shown.
module grid_strip_index_generator_core #(
	parameter int MAX_U_POINTS = 64,
	parameter int MAX_V_POINTS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gsig_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gsig_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            start,
	output logic                            busy,
	input  logic [gsig_pkg::STRIP_W-1:0]    strip_number,
	output logic                            result_valid,
	output logic [gsig_pkg::VTX_W-1:0]      first_vertex,
	output logic [gsig_pkg::VTX_W-1:0]      second_vertex,
	output logic [gsig_pkg::LEN_W-1:0]      strip_length,
	output logic                            last_pair
);
	import gsig_pkg::*;

	localparam logic [U_W-1:0] U_HI = (MAX_U_POINTS > 127) ? U_W'(127) : U_W'(MAX_U_POINTS);
	localparam logic [V_W-1:0] V_HI = (MAX_V_POINTS > 63) ? V_W'(63) : V_W'(MAX_V_POINTS);

	logic [U_W-1:0] u_points_q;
	logic [V_W-1:0] v_points_q;
	logic           join_u_q, join_v_q, twist_u_q, twist_v_q, clockwise_q;

	logic [U_W-1:0] nu;
	logic [V_W-1:0] nv;
	logic [U_W-1:0] nu_m1;
	logic           strip_ok, strip_wrap, accept;

	state_t         state_q, state_d;
	logic           wrap_q;
	logic [U_W-1:0] mult_q;
	vtx_t           addend_q, acc_q;
	vtx_t           start_a_q, start_b_q, cur_a_q, cur_b_q;
	logic [V_W-1:0] j_q;

	vtx_t           add_x, add_y, add_sum;
	logic           emit_vld, emit_last;
	vtx_t           emit_a, emit_b;
	logic           j_end;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_points_q  <= U_W'(2);
			v_points_q  <= V_W'(2);
			join_u_q    <= 1'b0;
			join_v_q    <= 1'b0;
			twist_u_q   <= 1'b0;
			twist_v_q   <= 1'b0;
			clockwise_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_U_POINTS:  u_points_q  <= cfg_data[U_W-1:0];
				REG_V_POINTS:  v_points_q  <= cfg_data[V_W-1:0];
				REG_JOIN_U:    join_u_q    <= cfg_data[0];
				REG_JOIN_V:    join_v_q    <= cfg_data[0];
				REG_TWIST_U:   twist_u_q   <= cfg_data[0];
				REG_TWIST_V:   twist_v_q   <= cfg_data[0];
				REG_CLOCKWISE: clockwise_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (u_points_q < U_W'(2))
			nu = U_W'(2);
		else if (u_points_q > U_HI)
			nu = U_HI;
		else
			nu = u_points_q;
		if (v_points_q < V_W'(2))
			nv = V_W'(2);
		else if (v_points_q > V_HI)
			nv = V_HI;
		else
			nv = v_points_q;
	end

	assign nu_m1      = nu - U_W'(1);
	assign strip_wrap = join_u_q && ({1'b0, strip_number} == nu_m1);
	assign strip_ok   = ({1'b0, strip_number} < nu_m1) || strip_wrap;
	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign j_end      = (j_q == nv - V_W'(1));

	// the one adder: shift-add steps, then second row base
	always_comb begin
		add_x = acc_q;
		add_y = '0;
		case (state_q)
			ST_MUL:  add_y = mult_q[0] ? addend_q : '0;
			ST_BASE: add_y = VTX_W'(nv);
			default: add_y = '0;
		endcase
	end
	assign add_sum = add_x + add_y;

	always_comb begin
		state_d   = state_q;
		emit_vld  = 1'b0;
		emit_last = 1'b0;
		emit_a    = cur_a_q;
		emit_b    = cur_b_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && strip_ok)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				if ((mult_q >> 1) == '0)
					state_d = ST_BASE;
			end
			ST_BASE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				emit_vld  = 1'b1;
				emit_last = !join_v_q && j_end;
				if (j_end)
					state_d = join_v_q ? ST_CLOSE : ST_IDLE;
			end
			ST_CLOSE: begin
				emit_vld  = 1'b1;
				emit_last = 1'b1;
				emit_a    = twist_v_q ? start_b_q : start_a_q;
				emit_b    = twist_v_q ? start_a_q : start_b_q;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					wrap_q   <= strip_wrap;
					mult_q   <= strip_wrap ? nu_m1 : {1'b0, strip_number};
					addend_q <= VTX_W'(nv);
					acc_q    <= '0;
				end
			end
			ST_MUL: begin
				acc_q    <= add_sum;
				mult_q   <= mult_q >> 1;
				addend_q <= addend_q << 1;
			end
			ST_BASE: begin
				start_a_q <= acc_q;
				cur_a_q   <= acc_q;
				j_q       <= '0;
				if (wrap_q) begin
					start_b_q <= twist_u_q ? VTX_W'(nv - V_W'(1)) : '0;
					cur_b_q   <= twist_u_q ? VTX_W'(nv - V_W'(1)) : '0;
				end else begin
					start_b_q <= add_sum;
					cur_b_q   <= add_sum;
				end
			end
			ST_EMIT: begin
				cur_a_q <= cur_a_q + VTX_W'(1);
				cur_b_q <= (wrap_q && twist_u_q) ? cur_b_q - VTX_W'(1) : cur_b_q + VTX_W'(1);
				j_q     <= j_q + V_W'(1);
			end
			default: ;
		endcase
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else
			result_valid <= emit_vld;
	end

	always_ff @(posedge clk) begin
		if (emit_vld) begin
			first_vertex  <= clockwise_q ? emit_a : emit_b;
			second_vertex <= clockwise_q ? emit_b : emit_a;
			strip_length  <= {nv, 1'b0} + (join_v_q ? LEN_W'(2) : LEN_W'(0));
			last_pair     <= emit_last;
		end
	end

	// no word appears in the cycle after a command is taken
	a_no_word_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !result_valid)
		else $error("word one cycle after command");

	// a word that is not the last leaves the sequencer running
	a_mid_strip_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_pair) |-> busy)
		else $error("sequencer idle in mid strip");

	// the last word closes the strip
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_pair) |=> !result_valid)
		else $error("word right after last pair");

	// words come only from a running sequencer
	a_word_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("word while idle");

endmodule
